>>> sv/sbq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_pkg: shared types and constants for the stereo biquad cascade
// Coefficient bank layout, register map, section schedule and the command
// word that the controller hands to the datapath.
// ----------------------------------------------------------------------------
package sbq_pkg;

    localparam int SBQ_SAMPLE_BITS    = 24;
    localparam int SBQ_COEF_FRAC_BITS = 29;
    localparam int SBQ_STATE_BITS     = 48;

    localparam int COEF_BITS  = 32;
    localparam int CFG_BITS   = 2 * COEF_BITS;
    localparam int CFG_IDX_W  = 3;

    // sections in order left A, left B, right A, right B
    localparam int NUM_SECTIONS = 4;
    localparam int SEC_IDX_W    = $clog2(NUM_SECTIONS);

    // spacing of section starts and length of one section in the overlapped schedule
    localparam int SEC_PERIOD = 6;
    localparam int SEC_SPAN   = 8;
    localparam int RUN_STEPS  = SEC_PERIOD * (NUM_SECTIONS - 1) + SEC_SPAN;
    localparam int STEP_W     = $clog2(RUN_STEPS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A_B0_B1 = 3'd0,
        REG_A_B2_A1 = 3'd1,
        REG_A_A2    = 3'd2,
        REG_B_B0_B1 = 3'd3,
        REG_B_B2_A1 = 3'd4,
        REG_B_A2    = 3'd5,
        REG_BYPASS  = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        C_B0,
        C_B1,
        C_B2,
        C_A1,
        C_A2
    } t_coef_sel;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
    } t_sec_coefs;

    // index 0 is stage A, index 1 is stage B
    typedef t_sec_coefs [1:0] t_coef_bank;

    typedef struct packed {
        logic                 in_load;
        logic                 mul_en;
        logic                 mul_stage;
        t_coef_sel            mul_coef;
        logic                 mul_src_y;
        logic                 acc_en;
        logic [SEC_IDX_W-1:0] acc_idx;
        logic                 y_en;
        logic                 n1_load;
        logic                 n2_load;
        logic                 n1_sub;
        logic                 x_from_y;
        logic                 x_from_right;
        logic                 left_capture;
        logic                 z_wr;
        logic [SEC_IDX_W-1:0] wr_idx;
        logic                 out_load;
        logic                 out_bypass;
    } t_cmd;

endpackage

>>> sv/sbq_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_cfg_regs: coefficient and bypass registers
// Write-only register file; 64-bit writes carry up to two coefficients,
// upper half first; a2 sits in the lower half, bypass in bit 0.
// ----------------------------------------------------------------------------
module sbq_cfg_regs
    import sbq_pkg::*;
#(
    parameter int COEF_FRAC_BITS = SBQ_COEF_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]  i_cfg_data,
    output t_coef_bank           o_coefs,
    output logic                 o_bypass
);

    localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;
    // b0 = 1.0, everything else zero
    localparam t_sec_coefs SEC_RESET = {COEF_ONE, {(4 * COEF_BITS){1'b0}}};

    t_coef_bank              r_coefs;
    logic                    r_bypass;
    logic [COEF_BITS-1:0]    w_hi;
    logic [COEF_BITS-1:0]    w_lo;

    assign w_hi = i_cfg_data[CFG_BITS-1:COEF_BITS];
    assign w_lo = i_cfg_data[COEF_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs  <= {SEC_RESET, SEC_RESET};
            r_bypass <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_A_B0_B1: begin
                    r_coefs[0].b0 <= w_hi;
                    r_coefs[0].b1 <= w_lo;
                end
                REG_A_B2_A1: begin
                    r_coefs[0].b2 <= w_hi;
                    r_coefs[0].a1 <= w_lo;
                end
                REG_A_A2: begin
                    r_coefs[0].a2 <= w_lo;
                end
                REG_B_B0_B1: begin
                    r_coefs[1].b0 <= w_hi;
                    r_coefs[1].b1 <= w_lo;
                end
                REG_B_B2_A1: begin
                    r_coefs[1].b2 <= w_hi;
                    r_coefs[1].a1 <= w_lo;
                end
                REG_B_A2: begin
                    r_coefs[1].a2 <= w_lo;
                end
                REG_BYPASS: begin
                    r_bypass <= i_cfg_data[0];
                end
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    assign o_coefs  = r_coefs;
    assign o_bypass = r_bypass;

endmodule

>>> sv/sbq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_ctrl: sequencer for the biquad cascade
// Handles both stream handshakes and issues one command word per cycle,
// running the four sections on a fixed overlapped schedule.
// ----------------------------------------------------------------------------
module sbq_ctrl
    import sbq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    input  logic i_bypass,
    output t_cmd o_cmd
);

    // cycle offsets inside one section
    localparam int OFS_B0  = 0;
    localparam int OFS_B1  = 1;
    localparam int OFS_B2  = 2;
    localparam int OFS_ACC = 2;
    localparam int OFS_Y   = 3;
    localparam int OFS_N2  = 4;
    localparam int OFS_A1  = 4;
    localparam int OFS_A2  = 5;
    localparam int OFS_SUB = 6;
    localparam int OFS_WR  = 7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FINISH
    } t_state;

    t_state              r_state;
    logic [STEP_W-1:0]   r_step;
    logic                r_m_valid;
    t_cmd                w_cmd;

    function automatic logic at_step(input logic [STEP_W-1:0] step, input int sec,
                                     input int ofs);
        return step == STEP_W'(SEC_PERIOD * sec + ofs);
    endfunction

    always_comb begin
        w_cmd            = '0;
        w_cmd.mul_coef   = C_B0;
        w_cmd.in_load    = (r_state == S_IDLE) && i_s_tvalid;
        w_cmd.out_load   = (r_state == S_FINISH) && (!r_m_valid || i_m_tready);
        w_cmd.out_bypass = i_bypass;
        if (r_state == S_RUN) begin
            for (int j = 0; j < NUM_SECTIONS; j++) begin
                if (at_step(r_step, j, OFS_B0)) begin
                    w_cmd.mul_en    = 1'b1;
                    w_cmd.mul_stage = j[0];
                    w_cmd.mul_coef  = C_B0;
                end
                if (at_step(r_step, j, OFS_B1)) begin
                    w_cmd.mul_en    = 1'b1;
                    w_cmd.mul_stage = j[0];
                    w_cmd.mul_coef  = C_B1;
                end
                if (at_step(r_step, j, OFS_B2)) begin
                    w_cmd.mul_en    = 1'b1;
                    w_cmd.mul_stage = j[0];
                    w_cmd.mul_coef  = C_B2;
                end
                if (at_step(r_step, j, OFS_A1)) begin
                    w_cmd.mul_en    = 1'b1;
                    w_cmd.mul_stage = j[0];
                    w_cmd.mul_coef  = C_A1;
                    w_cmd.mul_src_y = 1'b1;
                end
                if (at_step(r_step, j, OFS_A2)) begin
                    w_cmd.mul_en    = 1'b1;
                    w_cmd.mul_stage = j[0];
                    w_cmd.mul_coef  = C_A2;
                    w_cmd.mul_src_y = 1'b1;
                end
                if (at_step(r_step, j, OFS_ACC)) begin
                    w_cmd.acc_en  = 1'b1;
                    w_cmd.acc_idx = SEC_IDX_W'(j);
                end
                if (at_step(r_step, j, OFS_Y)) begin
                    w_cmd.y_en    = 1'b1;
                    w_cmd.n1_load = 1'b1;
                end
                if (at_step(r_step, j, OFS_N2)) begin
                    w_cmd.n2_load = 1'b1;
                    // left B hands over to right A, left A and right A feed the next one
                    if (j == 1) begin
                        w_cmd.left_capture = 1'b1;
                        w_cmd.x_from_right = 1'b1;
                    end else if (j < NUM_SECTIONS - 1) begin
                        w_cmd.x_from_y = 1'b1;
                    end
                end
                if (at_step(r_step, j, OFS_SUB)) begin
                    w_cmd.n1_sub = 1'b1;
                end
                if (at_step(r_step, j, OFS_WR)) begin
                    w_cmd.z_wr   = 1'b1;
                    w_cmd.wr_idx = SEC_IDX_W'(j);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    if (i_s_tvalid) begin
                        r_state <= i_bypass ? S_FINISH : S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_step == STEP_W'(RUN_STEPS - 1)) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_FINISH: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_cmd.out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_cmd      = w_cmd;

endmodule

>>> sv/sbq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_datapath: shared multiplier, alignment and saturating accumulate
// One 32 x sample multiplier feeds a product register, then an alignment
// register; section delays live in two small register arrays.
// ----------------------------------------------------------------------------
module sbq_datapath
    import sbq_pkg::*;
#(
    parameter int SAMPLE_BITS    = SBQ_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = SBQ_COEF_FRAC_BITS,
    parameter int STATE_BITS     = SBQ_STATE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  t_coef_bank                    i_coefs,
    input  logic signed [SAMPLE_BITS-1:0] i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_right_sample,
    output logic signed [SAMPLE_BITS-1:0] o_left_out,
    output logic signed [SAMPLE_BITS-1:0] o_right_out
);

    // fraction bits of the delay values
    localparam int FRAC_S = (STATE_BITS - SAMPLE_BITS - 4 > 0) ?
                            STATE_BITS - SAMPLE_BITS - 4 : 0;
    localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
    localparam int AW     = PROD_W + COEF_BITS;
    localparam int SH_UP  = (FRAC_S >= COEF_FRAC_BITS) ? FRAC_S - COEF_FRAC_BITS : 0;
    localparam int SH_DN  = (FRAC_S < COEF_FRAC_BITS) ? COEF_FRAC_BITS - FRAC_S : 0;
    localparam int P_POS  = (SH_DN > 0) ? SH_DN - 1 : 0;
    localparam int Y_POS  = (FRAC_S > 0) ? FRAC_S - 1 : 0;

    localparam logic signed [AW-1:0] P_RND = (SH_DN > 0) ? (AW'(1) << P_POS) : '0;
    localparam logic signed [AW-1:0] Y_RND = (FRAC_S > 0) ? (AW'(1) << Y_POS) : '0;
    localparam logic signed [AW-1:0] ST_MAX =
        {{(AW - STATE_BITS + 1){1'b0}}, {(STATE_BITS - 1){1'b1}}};
    localparam logic signed [AW-1:0] ST_MIN = ~ST_MAX;
    localparam logic signed [AW-1:0] SP_MAX =
        {{(AW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [AW-1:0] SP_MIN = ~SP_MAX;

    function automatic logic signed [AW-1:0] ext_st(input logic signed [STATE_BITS-1:0] v);
        return {{(AW - STATE_BITS){v[STATE_BITS-1]}}, v};
    endfunction

    function automatic logic signed [STATE_BITS-1:0] sat_st(input logic signed [AW-1:0] v);
        logic signed [STATE_BITS-1:0] res;
        if (v > ST_MAX) begin
            res = ST_MAX[STATE_BITS-1:0];
        end else if (v < ST_MIN) begin
            res = ST_MIN[STATE_BITS-1:0];
        end else begin
            res = v[STATE_BITS-1:0];
        end
        return res;
    endfunction

    logic signed [SAMPLE_BITS-1:0] r_in_l;
    logic signed [SAMPLE_BITS-1:0] r_in_r;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic signed [SAMPLE_BITS-1:0] r_left_res;
    logic signed [SAMPLE_BITS-1:0] r_out_l;
    logic signed [SAMPLE_BITS-1:0] r_out_r;
    logic signed [PROD_W-1:0]      r_p;
    logic signed [STATE_BITS-1:0]  r_a;
    logic signed [STATE_BITS-1:0]  r_acc;
    logic signed [STATE_BITS-1:0]  r_n1;
    logic signed [STATE_BITS-1:0]  r_n2;
    logic signed [STATE_BITS-1:0]  r_z1 [NUM_SECTIONS];
    logic signed [STATE_BITS-1:0]  r_z2 [NUM_SECTIONS];

    t_sec_coefs                    w_sec;
    logic signed [COEF_BITS-1:0]   w_coef;
    logic signed [SAMPLE_BITS-1:0] w_opnd;
    logic signed [AW-1:0]          w_p_ext;
    logic signed [AW-1:0]          w_al;
    logic signed [AW-1:0]          w_y_wide;
    logic signed [SAMPLE_BITS-1:0] w_y;

    // coefficient select for the shared multiplier
    always_comb begin
        w_sec = i_coefs[i_cmd.mul_stage];
        unique case (i_cmd.mul_coef)
            C_B0:    w_coef = w_sec.b0;
            C_B1:    w_coef = w_sec.b1;
            C_B2:    w_coef = w_sec.b2;
            C_A1:    w_coef = w_sec.a1;
            C_A2:    w_coef = w_sec.a2;
            default: w_coef = w_sec.b0;
        endcase
    end

    assign w_opnd = i_cmd.mul_src_y ? r_y : r_x;

    // product to delay scale: round half up on the way down, exact shift up
    assign w_p_ext = {{(AW - PROD_W){r_p[PROD_W-1]}}, r_p};
    assign w_al    = ((w_p_ext + P_RND) >>> SH_DN) <<< SH_UP;

    // section output: round accumulator to a whole sample and clip
    always_comb begin
        w_y_wide = (ext_st(r_acc) + Y_RND) >>> FRAC_S;
        if (w_y_wide > SP_MAX) begin
            w_y = SP_MAX[SAMPLE_BITS-1:0];
        end else if (w_y_wide < SP_MIN) begin
            w_y = SP_MIN[SAMPLE_BITS-1:0];
        end else begin
            w_y = w_y_wide[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= sat_st(w_al);
        if (i_cmd.in_load) begin
            r_in_l <= i_left_sample;
            r_in_r <= i_right_sample;
            r_x    <= i_left_sample;
        end
        if (i_cmd.mul_en) begin
            r_p <= w_coef * w_opnd;
        end
        if (i_cmd.acc_en) begin
            r_acc <= sat_st(ext_st(r_a) + ext_st(r_z1[i_cmd.acc_idx]));
        end
        if (i_cmd.y_en) begin
            r_y <= w_y;
        end
        if (i_cmd.n1_load) begin
            r_n1 <= r_a;
        end else if (i_cmd.n1_sub) begin
            r_n1 <= sat_st(ext_st(r_n1) - ext_st(r_a));
        end
        if (i_cmd.n2_load) begin
            r_n2 <= r_a;
        end
        if (i_cmd.x_from_y) begin
            r_x <= r_y;
        end
        if (i_cmd.x_from_right) begin
            r_x <= r_in_r;
        end
        if (i_cmd.left_capture) begin
            r_left_res <= r_y;
        end
        if (i_cmd.out_load) begin
            r_out_l <= i_cmd.out_bypass ? r_in_l : r_left_res;
            r_out_r <= i_cmd.out_bypass ? r_in_r : r_y;
        end
    end

    // delay state, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SECTIONS; i++) begin
                r_z1[i] <= '0;
                r_z2[i] <= '0;
            end
        end else if (i_cmd.z_wr) begin
            r_z1[i_cmd.wr_idx] <= sat_st(ext_st(r_n1) + ext_st(r_z2[i_cmd.wr_idx]));
            r_z2[i_cmd.wr_idx] <= sat_st(ext_st(r_n2) - ext_st(r_a));
        end
    end

    assign o_left_out  = r_out_l;
    assign o_right_out = r_out_r;

endmodule

>>> sv/stereo_biquad_cascade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_biquad_cascade: two-section stereo biquad filter, fixed point
// Transposed direct form II, sections A then B per channel, shared
// coefficients in signed Q3.COEF_FRAC_BITS, saturating arithmetic.
// ----------------------------------------------------------------------------
// One stereo word in, one stereo word out. With filtering on, a word passes
// through the accepting cycle, a run in which one shared multiplier issues
// five products per section, each section starting while the one before it
// is still finishing (four sections: left A, left B, right A, right B), and
// the load of the result into the output register, which waits while that
// register still holds a result not yet taken. In bypass a word goes from
// the accepting cycle straight to that load; the delay state stays untouched.
// The block takes one word at a time; the next word is accepted as soon as the
// result sits in the output register, whether or not it has been taken yet.
// Coefficient and bypass writes are only safe while no word is in flight.
// ----------------------------------------------------------------------------
module stereo_biquad_cascade
    import sbq_pkg::*;
#(
    parameter int SAMPLE_BITS    = SBQ_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = SBQ_COEF_FRAC_BITS,
    parameter int STATE_BITS     = SBQ_STATE_BITS,
    localparam int TDATA_W       = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,   // left_sample, right_sample, zero pad
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // left_out, right_out, zero pad
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]  i_cfg_data
);

    t_coef_bank                    w_coefs;
    logic                          w_bypass;
    t_cmd                          w_cmd;
    logic signed [SAMPLE_BITS-1:0] w_left_out;
    logic signed [SAMPLE_BITS-1:0] w_right_out;

    sbq_cfg_regs #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coefs    (w_coefs),
        .o_bypass   (w_bypass)
    );

    sbq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_bypass   (w_bypass),
        .o_cmd      (w_cmd)
    );

    sbq_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .STATE_BITS     (STATE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_coefs        (w_coefs),
        .i_left_sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_right_sample (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .o_left_out     (w_left_out),
        .o_right_out    (w_right_out)
    );

    assign m_axis_tdata = TDATA_W'({w_right_out, w_left_out});

endmodule

>>> sv/sbq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_checker: port-level checks for the stereo biquad cascade
// Tracks words in flight from the two handshakes and checks occupancy and
// output hold behaviour.
// ----------------------------------------------------------------------------
module sbq_checker #(
    parameter int TDATA_W = 48
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_s_tvalid,
    input logic               i_s_tready,
    input logic               i_m_tvalid,
    input logic               i_m_tready,
    input logic [TDATA_W-1:0] i_m_tdata
);

    logic [1:0] r_pending;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_s_tvalid && i_s_tready;
    assign w_out_acc = i_m_tvalid && i_m_tready;

    // words accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_pending <= r_pending + 1'b1;
        end else if (w_out_acc && !w_in_acc) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("output word changed or dropped while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_s_tready)
        else $error("input still ready right after a word was taken");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> r_pending != 2'd0)
        else $error("output valid with no word in flight");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == 2'd2 |-> !i_s_tready)
        else $error("input ready while a result waits and a word is in work");

endmodule

bind stereo_biquad_cascade sbq_checker #(
    .TDATA_W (TDATA_W)
) u_sbq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
